// ----- hw/rtl/ecad_pkg.sv -----
package ecad_pkg;

  // surface geometry and timestamp width
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int TS_BITS    = 32;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = 1 + XW + YW;
  localparam int DEPTH = 2 * MAX_HEIGHT * MAX_WIDTH;

  // coordinate arithmetic width, holds any pixel, register or surface size
  localparam int CW = 12;

  localparam int BORDER   = 4;
  localparam int RING3_N  = 16;
  localparam int RING4_N  = 20;
  localparam int RING_MAX = RING4_N;
  localparam int RIW      = $clog2(RING_MAX + 1);
  localparam int R3W      = $clog2(RING3_N);

  localparam int ARC3_MIN = 3;
  localparam int ARC3_MAX = 6;
  localparam int ARC4_MIN = 4;
  localparam int ARC4_MAX = 8;

  // register indexes, decoded from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [8:0] WIDTH_RST  = 9'd240;
  localparam logic [8:0] HEIGHT_RST = 9'd180;

  typedef logic signed [3:0] ofs_t;

  localparam ofs_t R3_DX [RING3_N] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd3, 4'sd2, 4'sd1,
    4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1};
  localparam ofs_t R3_DY [RING3_N] = '{
    4'sd3, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3,
    -4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};

  localparam ofs_t R4_DX [RING4_N] = '{
    4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd4, 4'sd4, 4'sd3,
    4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd4,
    -4'sd4, -4'sd3, -4'sd2, -4'sd1};
  localparam ofs_t R4_DY [RING4_N] = '{
    4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2,
    -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0,
    4'sd1, 4'sd2, 4'sd3, 4'sd4};

  // sequencer to arc unit
  typedef struct packed {
    logic load;   // shift in read word
    logic eval;   // build threshold mask, rotate ring
    logic check;  // test registered mask
    logic clear;  // drop found flag
    logic ring4;  // outer ring selected
  } arc_ctrl_t;

endpackage

// ----- hw/rtl/ecad_ram.sv -----
module ecad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ecad_arc_unit.sv -----
module ecad_arc_unit import ecad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arc_ctrl_t          ctrl_i,
  input  logic [TS_BITS-1:0] rdata_i,
  output logic               found_o
);

  logic [TS_BITS-1:0]  vals_q [RING_MAX];
  logic [TS_BITS-1:0]  vals_d [RING_MAX];
  logic [TS_BITS-1:0]  ins;
  logic [RING_MAX-1:0] mask_q, mask_d;
  logic [RING_MAX-1:0] rise;
  logic [RIW-1:0]      last_idx, ring_n, arc_min, arc_max, ones;
  logic                found_q, arc_ok, prev0;

  assign last_idx = ctrl_i.ring4 ? RIW'(RING4_N - 1) : RIW'(RING3_N - 1);
  assign ring_n   = ctrl_i.ring4 ? RIW'(RING4_N) : RIW'(RING3_N);
  assign arc_min  = ctrl_i.ring4 ? RIW'(ARC4_MIN) : RIW'(ARC3_MIN);
  assign arc_max  = ctrl_i.ring4 ? RIW'(ARC4_MAX) : RIW'(ARC3_MAX);
  assign ins      = ctrl_i.load ? rdata_i : vals_q[0];

  // ring words shift toward slot 0: loading fills the ring, eval rotates it
  always_comb begin
    vals_d = vals_q;
    if (ctrl_i.load || ctrl_i.eval) begin
      for (int i = 0; i < RING_MAX; i++) begin
        if (i == int'(last_idx)) begin
          vals_d[i] = ins;
        end else begin
          vals_d[i] = vals_q[(i + 1) % RING_MAX];
        end
      end
    end
  end

  // points at least as new as the current threshold point
  always_comb begin
    for (int i = 0; i < RING_MAX; i++) begin
      mask_d[i] = (i < int'(ring_n)) && (vals_q[i] >= vals_q[0]);
    end
  end

  // mask is a valid arc when it is one circular run of allowed length
  assign prev0 = ctrl_i.ring4 ? mask_q[RING4_N-1] : mask_q[RING3_N-1];
  always_comb begin
    ones = '0;
    for (int i = 0; i < RING_MAX; i++) begin
      ones = ones + RIW'(mask_q[i]);
    end
    rise[0] = mask_q[0] & ~prev0;
    for (int i = 1; i < RING_MAX; i++) begin
      rise[i] = mask_q[i] & ~mask_q[i-1];
    end
  end

  assign arc_ok = (ones >= arc_min) && (ones <= arc_max) && (rise != '0) &&
                  ((rise & (rise - RING_MAX'(1))) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctrl_i.check && arc_ok) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    vals_q <= vals_d;
    if (ctrl_i.eval) begin
      mask_q <= mask_d;
    end
  end

  assign found_o = found_q | (ctrl_i.check & arc_ok);

endmodule

// ----- hw/rtl/event_corner_arc_detector_top.sv -----
// off-surface or border-band events skip the search; otherwise the inner ring is
//   searched, and the outer one too when it has an arc; one event at a time:
//   in_ready_o is low until the result is registered and in the clearing pass; the
//   search is paced by the single-port surface memory (one ring word a cycle) and
//   the arc unit (one threshold point a cycle); reset sets the size to 240 x 180,
//   then the pass zeroes 2*MAX_HEIGHT*MAX_WIDTH = 131072 words one word a cycle
module event_corner_arc_detector_top import ecad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic        polarity_i,
  input  logic [31:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_corner_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_e;

  state_e             state_q, state_d;
  logic [RIW-1:0]     cnt_q, cnt_d;
  logic               ring4_q, ring4_d;
  logic               corner_q, corner_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic               is_corner_q, is_corner_d;
  logic [7:0]         x_q, x_d, y_q, y_d;
  logic               pol_q, pol_d;
  logic [TS_BITS-1:0] ts_q, ts_d;
  logic [8:0]         width_q, height_q;

  logic               cfg_wr;
  logic [RIW-1:0]     ring_n, ridx;
  ofs_t               dx, dy;
  logic [CW-1:0]      xw, yw, xr, yr, w_lim, h_lim, w_eff, h_eff;
  logic               in_surface, border_ok;
  logic               ram_we;
  logic [AW-1:0]      ram_addr, ring_addr, ctr_addr;
  logic [TS_BITS-1:0] ram_wdata, ram_rdata;
  arc_ctrl_t          arc_ctrl;
  logic               arc_found;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[8:0];
        REG_HEIGHT: height_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- address and border logic ----------------
  assign xw = CW'(x_q);
  assign yw = CW'(y_q);

  assign in_surface = (xw < CW'(MAX_WIDTH)) && (yw < CW'(MAX_HEIGHT));

  assign w_lim = CW'(width_q);
  assign h_lim = CW'(height_q);
  assign w_eff = (w_lim > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_lim;
  assign h_eff = (h_lim > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : h_lim;
  assign border_ok = (xw >= CW'(BORDER)) && (xw + CW'(BORDER) < w_eff) &&
                     (yw >= CW'(BORDER)) && (yw + CW'(BORDER) < h_eff);

  assign ring_n = ring4_q ? RIW'(RING4_N) : RIW'(RING3_N);
  assign ridx   = (cnt_q < ring_n) ? cnt_q : '0;
  assign dx     = ring4_q ? R4_DX[ridx] : R3_DX[ridx[R3W-1:0]];
  assign dy     = ring4_q ? R4_DY[ridx] : R3_DY[ridx[R3W-1:0]];
  assign xr     = xw + CW'(dx);
  assign yr     = yw + CW'(dy);

  assign ring_addr = {pol_q, yr[YW-1:0], xr[XW-1:0]};
  assign ctr_addr  = {pol_q, yw[YW-1:0], xw[XW-1:0]};

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ts_q;
    ram_addr  = ring_addr;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = clr_q;
      end
      S_WRITE: begin
        ram_we   = in_surface;
        ram_addr = ctr_addr;
      end
      default: ;
    endcase
  end

  ecad_ram #(
    .WIDTH(TS_BITS),
    .DEPTH(DEPTH)
  ) u_surface (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // ---------------- arc unit ----------------
  always_comb begin
    arc_ctrl.load  = (state_q == S_READ) && (cnt_q != '0);
    arc_ctrl.clear = (state_q == S_READ) && (cnt_q == '0);
    arc_ctrl.eval  = (state_q == S_EVAL) && (cnt_q < ring_n);
    arc_ctrl.check = (state_q == S_EVAL) && (cnt_q != '0);
    arc_ctrl.ring4 = ring4_q;
  end

  ecad_arc_unit u_arc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (arc_ctrl),
    .rdata_i(ram_rdata),
    .found_o(arc_found)
  );

  // ---------------- sequencer ----------------
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_corner_o = is_corner_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ring4_d     = ring4_q;
    corner_d    = corner_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_corner_d = is_corner_q;
    x_d         = x_q;
    y_d         = y_q;
    pol_d       = pol_q;
    ts_d        = ts_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = pixel_x_i;
          y_d     = pixel_y_i;
          pol_d   = polarity_i;
          ts_d    = TS_BITS'(timestamp_i);
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        corner_d = 1'b0;
        ring4_d  = 1'b0;
        cnt_d    = '0;
        if (in_surface && border_ok) begin
          state_d = S_READ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        // one word read per cycle, its data registered by the RAM and landing in the next cycle
        if (cnt_q == ring_n) begin
          cnt_d   = '0;
          state_d = S_EVAL;
        end else begin
          cnt_d = cnt_q + RIW'(1);
        end
      end
      S_EVAL: begin
        if (cnt_q == ring_n) begin
          cnt_d = '0;
          if (!ring4_q && arc_found) begin
            ring4_d = 1'b1;
            state_d = S_READ;
          end else begin
            corner_d = ring4_q && arc_found;
            state_d  = S_FINISH;
          end
        end else begin
          cnt_d = cnt_q + RIW'(1);
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          is_corner_d = corner_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      ring4_q     <= 1'b0;
      corner_q    <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      is_corner_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      pol_q       <= 1'b0;
      ts_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ring4_q     <= ring4_d;
      corner_q    <= corner_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      is_corner_q <= is_corner_d;
      x_q         <= x_d;
      y_q         <= y_d;
      pol_q       <= pol_d;
      ts_q        <= ts_d;
    end
  end

  // ---------------- assertions ----------------
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR) || (state_q == S_WRITE))
    else $error("surface written outside clear pass or event write");

  a_accept_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> (state_q == S_WRITE))
    else $error("accepted word did not start the surface write");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) || (state_q == S_EVAL) |-> (cnt_q <= ring_n))
    else $error("ring counter beyond ring size");

  a_corner_needs_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) && corner_q |-> ring4_q)
    else $error("corner flagged without outer ring search");

endmodule

// ----- verif/event_corner_arc_detector_top_tb.sv -----
`timescale 1ns / 1ps

module event_corner_arc_detector_top_tb;
  import ecad_pkg::*;

  // no word moves during the clearing pass after reset, which zeroes all 131072 surface words
  localparam int WATCHDOG_LIMIT = 600000;
  localparam int SETTLE_CYCLES  = 100;

  // inner and outer ring offsets, starting straight at +y from the pixel and turning toward +x
  localparam int INNER_DX [16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int INNER_DY [16] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
  localparam int OUTER_DX [20] = '{0, 1, 2, 3, 4, 4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4,
                                   -4, -3, -2, -1};
  localparam int OUTER_DY [20] = '{4, 4, 3, 2, 1, 0, -1, -2, -3, -4, -4, -4, -3, -2, -1, 0,
                                   1, 2, 3, 4};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  pixel_x_i   = '0;
  logic [7:0]  pixel_y_i   = '0;
  logic        polarity_i  = 1'b0;
  logic [31:0] timestamp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        is_corner_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // per-polarity surface of latest timestamps, zero after reset
  bit   [31:0] surface_ts [2][MAX_HEIGHT][MAX_WIDTH];
  logic [8:0]  sensor_w = WIDTH_RST;
  logic [8:0]  sensor_h = HEIGHT_RST;
  bit          expected_corners [$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int          sent_items  = 0;
  int          hold_left   = 0;
  logic [31:0] now_ts      = 32'd16;
  bit          tx_gaps     = 1'b1;
  bit          rx_stalls   = 1'b1;

  event_corner_arc_detector_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .polarity_i (polarity_i),
    .timestamp_i(timestamp_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_corner_o(is_corner_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  // arc whose oldest point is strictly newer than every point outside it
  function automatic bit ring_has_arc(input bit [31:0] pts [20], input int n,
                                      input int lo, input int hi);
    bit [31:0] oldest;
    bit        ok;
    for (int s = 0; s < n; s++) begin
      for (int len = lo; len <= hi; len++) begin
        if (pts[s] < pts[(s + n - 1) % n]) continue;
        if (pts[(s + len - 1) % n] < pts[(s + len) % n]) continue;
        oldest = pts[s];
        for (int j = 1; j < len; j++) begin
          if (pts[(s + j) % n] < oldest) oldest = pts[(s + j) % n];
        end
        ok = 1'b1;
        for (int j = len; j < n; j++) begin
          if (pts[(s + j) % n] >= oldest) ok = 1'b0;
        end
        if (ok) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit predict_corner(input logic [7:0] x, input logic [7:0] y,
                                        input logic pol, input logic [31:0] ts);
    int        w;
    int        h;
    int        cx;
    int        cy;
    bit [31:0] pts [20];
    surface_ts[pol][y][x] = ts;
    w  = (sensor_w > MAX_WIDTH) ? MAX_WIDTH : int'(sensor_w);
    h  = (sensor_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(sensor_h);
    cx = x;
    cy = y;
    if (cx < BORDER || cx >= w - BORDER || cy < BORDER || cy >= h - BORDER) return 1'b0;
    for (int i = 0; i < 16; i++) pts[i] = surface_ts[pol][cy + INNER_DY[i]][cx + INNER_DX[i]];
    if (!ring_has_arc(pts, 16, ARC3_MIN, ARC3_MAX)) return 1'b0;
    for (int i = 0; i < 20; i++) pts[i] = surface_ts[pol][cy + OUTER_DY[i]][cx + OUTER_DX[i]];
    return ring_has_arc(pts, 20, ARC4_MIN, ARC4_MAX);
  endfunction

  function automatic int pick_center(input int span);
    if (span - BORDER - 1 >= BORDER) return $urandom_range(BORDER, span - BORDER - 1);
    return $urandom_range(BORDER, 255 - BORDER);
  endfunction

  // valid stays high from one word to the next unless a gap is taken
  task automatic send_event(input logic [7:0] x, input logic [7:0] y, input logic pol,
                            input logic [31:0] ts);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_x_i   <= x;
    pixel_y_i   <= y;
    polarity_i  <= pol;
    timestamp_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    expected_corners.push_back(predict_corner(x, y, pol, ts));
  endtask

  // fresh arc on the inner ring, then on the outer ring, then the center event
  task automatic send_arc_burst(input int cx, input int cy, input logic pol,
                                input int len3, input int dir3, input int len4, input int dir4,
                                input int min_step, input int max_step, input int flip_pct);
    int   k;
    logic p;
    for (int i = 0; i < len3; i++) begin
      k = (dir3 + i) % 16;
      p = ($urandom_range(0, 99) < flip_pct) ? ~pol : pol;
      now_ts += $urandom_range(min_step, max_step);
      send_event(8'(cx + INNER_DX[k]), 8'(cy + INNER_DY[k]), p, now_ts);
    end
    for (int i = 0; i < len4; i++) begin
      k = (dir4 + i) % 20;
      p = ($urandom_range(0, 99) < flip_pct) ? ~pol : pol;
      now_ts += $urandom_range(min_step, max_step);
      send_event(8'(cx + OUTER_DX[k]), 8'(cy + OUTER_DY[k]), p, now_ts);
    end
    now_ts += $urandom_range(min_step, max_step);
    send_event(8'(cx), 8'(cy), pol, now_ts);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_corners.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {23'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic idx, input logic [8:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[8:0] !== want)
      note_mismatch($sformatf("register %0d expected %0d actual %0d", idx, want, prdata[8:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_sensor_area(input logic [8:0] w, input logic [8:0] h);
    wait_idle();
    write_reg(REG_WIDTH, w);
    sensor_w = w;
    write_reg(REG_HEIGHT, h);
    sensor_h = h;
    check_reg(REG_WIDTH, w);
    check_reg(REG_HEIGHT, h);
  endtask

  task automatic run_event_mix(input int n);
    int stop;
    int w;
    int h;
    int len3;
    int dir3;
    int mn;
    stop = sent_items + n;
    w    = (sensor_w > MAX_WIDTH) ? MAX_WIDTH : int'(sensor_w);
    h    = (sensor_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(sensor_h);
    while (sent_items < stop) begin
      if ($urandom_range(0, 11) == 0) begin
        tx_gaps   = ($urandom_range(0, 2) != 0);
        rx_stalls = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 9) < 7) begin
        len3 = $urandom_range(2, 8);
        dir3 = $urandom_range(0, 15);
        mn   = $urandom_range(0, 1);
        send_arc_burst(pick_center(w), pick_center(h), 1'($urandom_range(0, 1)), len3, dir3,
                       $urandom_range(3, 10), (dir3 * 5 / 4 + $urandom_range(0, 2) + 19) % 20,
                       mn, $urandom_range(mn, 4), 8);
      end else if ($urandom_range(0, 19) == 0) begin
        // out-of-order time kept in the left band
        send_event(8'($urandom_range(0, BORDER - 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), $urandom());
      end else begin
        now_ts += $urandom_range(0, 2);
        send_event(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), now_ts);
      end
    end
  endtask

  task automatic test_directed_edges();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_event(8'd0, 8'd0, 1'b0, 32'd0);
    send_event(8'd255, 8'd255, 1'b1, 32'hFFFF_FFFF);
    send_event(8'd3, 8'd40, 1'b0, now_ts);
    send_event(8'd235, 8'd40, 1'b0, now_ts);
    send_event(8'd236, 8'd40, 1'b1, now_ts);
    send_event(8'd40, 8'd3, 1'b1, now_ts);
    send_event(8'd40, 8'd176, 1'b0, now_ts);
    // clean corner on the on surface
    send_arc_burst(60, 60, 1'b1, 3, 2, 4, 2, 1, 3, 0);
    // an inner point outside the arc ties with the arc
    now_ts += 1;
    send_event(8'(100 + INNER_DX[12]), 8'(100 + INNER_DY[12]), 1'b0, now_ts);
    send_arc_burst(100, 100, 1'b0, 3, 4, 4, 5, 0, 0, 0);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  task automatic test_random_default();
    run_event_mix(300);
  endtask

  // receiver holds off while words keep coming, so the block backs up into its input
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    hold_left = 400;
    for (int i = 0; i < 3; i++) begin
      send_arc_burst(pick_center(MAX_WIDTH - 16), pick_center(160), 1'($urandom_range(0, 1)),
                     4, $urandom_range(0, 15), 6, $urandom_range(0, 19), 1, 2, 0);
    end
    tx_gaps = 1'b1;
  endtask

  task automatic test_area_settings();
    logic [8:0] widths  [6] = '{9'd256, 9'd511, 9'd9, 9'd8, 9'd0, 9'd137};
    logic [8:0] heights [6] = '{9'd256, 9'd9, 9'd300, 9'd0, 9'd511, 9'd61};
    int         counts  [6] = '{230, 120, 120, 30, 30, 230};
    for (int i = 0; i < 6; i++) begin
      set_sensor_area(widths[i], heights[i]);
      run_event_mix(counts[i]);
    end
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    bit want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_corners.size() == 0) begin
        note_mismatch($sformatf("is_corner %0d with no word expected", is_corner_o));
      end else begin
        want = expected_corners.pop_front();
        if (is_corner_o !== want)
          note_mismatch($sformatf("is_corner expected %0d actual %0d", want, is_corner_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("event_corner_arc_detector_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_edges();
    test_random_default();
    test_backpressure();
    test_area_settings();
    wait_idle();
    if (mismatches == 0 && expected_corners.size() == 0) begin
      $display("event_corner_arc_detector_top verification clean");
    end else begin
      $display("event_corner_arc_detector_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ecad_pkg.sv
hw/rtl/ecad_ram.sv
hw/rtl/ecad_arc_unit.sv
hw/rtl/event_corner_arc_detector_top.sv
verif/event_corner_arc_detector_top_tb.sv
